// ----- sv/rainbow_color_fade_sequencer_top_macros.svh -----
// assertion macros for the rainbow colour fade sequencer
// expects i_clk and i_rst_n in the scope of each use
`ifndef RAINBOW_COLOR_FADE_SEQUENCER_TOP_MACROS_SVH
`define RAINBOW_COLOR_FADE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define RCFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RCFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rcfs_pkg.sv -----
// shared types, constants and palette table for the rainbow colour fade sequencer
// no dependencies
package rcfs_pkg;

    // default parameter values
    parameter int FRACTION_BITS = 16;
    parameter int PALETTE_SIZE  = 7;

    // fixed field widths
    localparam int CFG_W      = 16;
    localparam int COLOR_W    = 8;
    localparam int PAL_IDX_W  = 5;
    localparam int DIVISOR_W  = 17;

    // register reset values
    localparam logic [CFG_W-1:0] FADE_STEPS_RST  = 16'd700;
    localparam logic [CFG_W-1:0] STEP_PERIOD_RST = 16'd10;

    // register indexes
    localparam logic CFG_FADE_STEPS  = 1'b0;
    localparam logic CFG_STEP_PERIOD = 1'b1;

    // one colour, channel 0 red, 1 green, 2 blue
    typedef logic [2:0][COLOR_W-1:0] t_rgb;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LWAIT,
        S_LOAD,
        S_DWAIT,
        S_ACC,
        S_OUT
    } t_state;

    // palette entry i is rainbow colour i mod 7
    function automatic t_rgb pal_color(logic [PAL_IDX_W-1:0] idx);
        t_rgb c;
        case (idx) inside
            5'd0, 5'd7, 5'd14, 5'd21, 5'd28: c = {8'd0,   8'd0,   8'd255};
            5'd1, 5'd8, 5'd15, 5'd22, 5'd29: c = {8'd0,   8'd165, 8'd255};
            5'd2, 5'd9, 5'd16, 5'd23, 5'd30: c = {8'd0,   8'd255, 8'd255};
            5'd3, 5'd10, 5'd17, 5'd24, 5'd31: c = {8'd0,  8'd255, 8'd0};
            5'd4, 5'd11, 5'd18, 5'd25:       c = {8'd255, 8'd0,   8'd0};
            5'd5, 5'd12, 5'd19, 5'd26:       c = {8'd130, 8'd0,   8'd75};
            5'd6, 5'd13, 5'd20, 5'd27:       c = {8'd238, 8'd130, 8'd238};
            default:                         c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/rcfs_serial_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module rcfs_serial_div #(
    parameter int DW = 30,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_div, n_div;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    // partial remainder with the next dividend bit shifted in
    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // restoring step: subtract when it fits
            if (!diff[VW]) begin
                n_rem = diff[VW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = trial[VW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sv/rainbow_color_fade_sequencer_top.sv -----
// top level of the rainbow colour fade sequencer: sequencer fsm, colour accumulators
// depends on rcfs_pkg, rcfs_serial_div and rainbow_color_fade_sequencer_top_macros.svh
//
// Usage:
//   Input channel (i_valid / o_stall) carries one beat per event: start_req 1 begins a
//   fade run when idle, start_req 0 is one millisecond tick. Output channel
//   (o_valid / i_stall) carries one fill colour per beat, last_fill marks the end of a run.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 fade_steps,
//   index 1 step_period; write only between runs or between ticks.
//   Processing: a beat that causes no fill is taken without leaving idle. Every other
//   beat runs the shared bit-serial divider once to find the segment length. A segment
//   start runs the divider three more times for the channel deltas. One beat is worked
//   on at a time; o_stall stays high meanwhile.
//   Reset: synchronous, active low; clears the run, the colour state and restores
//   fade_steps 700 and step_period 10.
//   Stall: a finished fill waits in the output register; the next beat is still taken,
//   and a further fill waits inside the block until that register frees.
`include "rainbow_color_fade_sequencer_top_macros.svh"

module rainbow_color_fade_sequencer_top #(
    parameter int FRACTION_BITS = rcfs_pkg::FRACTION_BITS,
    parameter int PALETTE_SIZE  = rcfs_pkg::PALETTE_SIZE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // event beats
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_start_req,
    // fill beats
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [rcfs_pkg::COLOR_W-1:0] o_red,
    output logic [rcfs_pkg::COLOR_W-1:0] o_green,
    output logic [rcfs_pkg::COLOR_W-1:0] o_blue,
    output logic                      o_last_fill,
    // register writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [rcfs_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW    = rcfs_pkg::COLOR_W + FRACTION_BITS;   // accumulator
    localparam int DLW   = AW + 1;                              // signed delta
    localparam int SW    = AW + 2;                              // sum before clamp
    localparam int DW    = 14 + FRACTION_BITS;                  // divider dividend
    localparam int VW    = rcfs_pkg::DIVISOR_W;
    localparam int CW    = rcfs_pkg::CFG_W;
    localparam int SEG_W = $clog2(PALETTE_SIZE + 1);
    localparam logic [AW-1:0] LIM  = {8'hFF, {FRACTION_BITS{1'b0}}};
    localparam logic [AW-1:0] HALF = AW'(1) << (FRACTION_BITS - 1);

    // registers
    rcfs_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_fade_steps, r_step_period;
    logic             r_busy, n_busy;
    logic             r_req, n_req;
    logic [SEG_W-1:0] r_seg, n_seg;
    logic [CW-1:0]    r_step, n_step;
    logic [CW-1:0]    r_tick, n_tick;
    logic [1:0]       r_ch, n_ch;
    logic             r_upd, n_upd;
    logic             r_last, n_last;
    logic [AW-1:0]    r_acc   [3];
    logic [AW-1:0]    n_acc   [3];
    logic signed [DLW-1:0] r_delta [3];
    logic signed [DLW-1:0] n_delta [3];
    rcfs_pkg::t_rgb   r_res, n_res;
    logic             r_out_valid, n_out_valid;
    rcfs_pkg::t_rgb   r_out, n_out;
    logic             r_out_last, n_out_last;

    // divider hookup
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quo;

    // helper logic
    logic             in_acc, out_acc, out_free;
    logic [CW-1:0]    period;
    logic             tick_done;
    logic [CW-1:0]    seg_len;
    logic [SEG_W-1:0] seg_inc, seg_nxt;
    rcfs_pkg::t_rgb   cur_col, nxt_col;
    logic [8:0]       col_diff;
    logic             col_neg;
    logic [7:0]       col_mag;
    logic [DW-1:0]    mag_prod;
    logic [DW-1:0]    delta_dividend;
    logic [AW-1:0]    q_sat;
    logic signed [DLW-1:0] delta_new;
    logic [AW-1:0]    round_sum;
    logic signed [SW-1:0] acc_sum;
    logic [AW-1:0]    acc_clamped;

    rcfs_serial_div #(
        .DW(DW),
        .VW(VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // handshakes
    assign o_stall     = (r_state != rcfs_pkg::S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_acc     = r_out_valid && !i_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // tick period, zero acts as one
    assign period    = (r_step_period == '0) ? CW'(1) : r_step_period;
    assign tick_done = !(({1'b0, r_tick} + (CW + 1)'(1)) < {1'b0, period});
    assign seg_len   = div_quo[CW-1:0];

    // segment colours and per-channel delta numerator
    assign seg_inc  = r_seg + SEG_W'(1);
    assign seg_nxt  = (seg_inc < SEG_W'(PALETTE_SIZE)) ? seg_inc : '0;
    assign cur_col  = rcfs_pkg::pal_color(rcfs_pkg::PAL_IDX_W'(r_seg));
    assign nxt_col  = rcfs_pkg::pal_color(rcfs_pkg::PAL_IDX_W'(seg_nxt));
    assign col_diff = {1'b0, nxt_col[r_ch]} - {1'b0, cur_col[r_ch]};
    assign col_neg  = col_diff[8];
    assign col_mag  = col_neg ? 8'(-col_diff) : col_diff[7:0];
    assign mag_prod = DW'(col_mag) * DW'(PALETTE_SIZE);
    assign delta_dividend = (mag_prod << (FRACTION_BITS + 1)) + DW'(r_fade_steps);

    // saturate and sign the quotient
    assign q_sat     = (div_quo > DW'(LIM)) ? LIM : div_quo[AW-1:0];
    assign delta_new = col_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

    // rounding and clamped add for the channel under r_ch
    assign round_sum = r_acc[r_ch] + HALF;
    assign acc_sum   = $signed({2'b00, r_acc[r_ch]}) + SW'(r_delta[r_ch]);
    always_comb begin
        if (acc_sum[SW-1]) begin
            acc_clamped = '0;
        end else if (acc_sum > $signed({2'b00, LIM})) begin
            acc_clamped = LIM;
        end else begin
            acc_clamped = acc_sum[AW-1:0];
        end
    end

    // divider source: segment length from idle, channel delta from load
    always_comb begin
        if (r_state == rcfs_pkg::S_LOAD) begin
            div_dividend = delta_dividend;
            div_divisor  = VW'({r_fade_steps, 1'b0});
        end else begin
            div_dividend = DW'({r_fade_steps, 1'b0}) + DW'(PALETTE_SIZE);
            div_divisor  = VW'(2 * PALETTE_SIZE);
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_req       = r_req;
        n_seg       = r_seg;
        n_step      = r_step;
        n_tick      = r_tick;
        n_ch        = r_ch;
        n_upd       = r_upd;
        n_last      = r_last;
        n_acc       = r_acc;
        n_delta     = r_delta;
        n_res       = r_res;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_out       = r_out;
        n_out_last  = r_out_last;
        div_start   = 1'b0;

        unique case (r_state)
            rcfs_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_start_req && !r_busy) begin
                        n_req     = 1'b1;
                        div_start = 1'b1;
                        n_state   = rcfs_pkg::S_LWAIT;
                    end else if (!i_start_req && r_busy) begin
                        if (tick_done) begin
                            n_tick    = '0;
                            n_req     = 1'b0;
                            div_start = 1'b1;
                            n_state   = rcfs_pkg::S_LWAIT;
                        end else begin
                            n_tick = r_tick + CW'(1);
                        end
                    end
                end
            end

            rcfs_pkg::S_LWAIT: begin
                if (div_done) begin
                    n_ch = '0;
                    if (r_req) begin
                        if (seg_len == '0) begin
                            // short run: a single violet fill
                            n_res   = rcfs_pkg::pal_color(
                                          rcfs_pkg::PAL_IDX_W'(PALETTE_SIZE - 1));
                            n_last  = 1'b1;
                            n_state = rcfs_pkg::S_OUT;
                        end else begin
                            n_seg   = '0;
                            n_step  = CW'(1);
                            n_tick  = '0;
                            n_busy  = 1'b1;
                            n_state = rcfs_pkg::S_LOAD;
                        end
                    end else if (r_step < seg_len) begin
                        n_step  = r_step + CW'(1);
                        n_upd   = 1'b1;
                        n_last  = 1'b0;
                        n_state = rcfs_pkg::S_ACC;
                    end else if (seg_inc < SEG_W'(PALETTE_SIZE)) begin
                        n_seg   = seg_inc;
                        n_step  = CW'(1);
                        n_state = rcfs_pkg::S_LOAD;
                    end else begin
                        // end of the palette: final fill, no update
                        n_busy  = 1'b0;
                        n_seg   = '0;
                        n_step  = '0;
                        n_upd   = 1'b0;
                        n_last  = 1'b1;
                        n_state = rcfs_pkg::S_ACC;
                    end
                end
            end

            rcfs_pkg::S_LOAD: begin
                n_acc[r_ch] = AW'(cur_col[r_ch]) << FRACTION_BITS;
                if (r_fade_steps == '0) begin
                    n_delta[r_ch] = '0;
                    if (r_ch == 2'd2) begin
                        n_ch    = '0;
                        n_upd   = 1'b1;
                        n_last  = 1'b0;
                        n_state = rcfs_pkg::S_ACC;
                    end else begin
                        n_ch = r_ch + 2'd1;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = rcfs_pkg::S_DWAIT;
                end
            end

            rcfs_pkg::S_DWAIT: begin
                if (div_done) begin
                    n_delta[r_ch] = delta_new;
                    if (r_ch == 2'd2) begin
                        n_ch    = '0;
                        n_upd   = 1'b1;
                        n_last  = 1'b0;
                        n_state = rcfs_pkg::S_ACC;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = rcfs_pkg::S_LOAD;
                    end
                end
            end

            rcfs_pkg::S_ACC: begin
                // emit the rounded level, then step the accumulator
                n_res[r_ch] = round_sum[AW-1:FRACTION_BITS];
                if (r_upd) begin
                    n_acc[r_ch] = acc_clamped;
                end
                if (r_ch == 2'd2) begin
                    n_ch    = '0;
                    n_state = rcfs_pkg::S_OUT;
                end else begin
                    n_ch = r_ch + 2'd1;
                end
            end

            rcfs_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_last  = r_last;
                    n_state     = rcfs_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rcfs_pkg::S_IDLE;
            end
        endcase
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcfs_pkg::S_IDLE;
            r_busy      <= 1'b0;
            r_req       <= 1'b0;
            r_seg       <= '0;
            r_step      <= '0;
            r_tick      <= '0;
            r_ch        <= '0;
            r_upd       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '{default: '0};
            r_delta     <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_req       <= n_req;
            r_seg       <= n_seg;
            r_step      <= n_step;
            r_tick      <= n_tick;
            r_ch        <= n_ch;
            r_upd       <= n_upd;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_delta     <= n_delta;
        end
    end

    // fill payload
    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_steps  <= rcfs_pkg::FADE_STEPS_RST;
            r_step_period <= rcfs_pkg::STEP_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rcfs_pkg::CFG_FADE_STEPS:  r_fade_steps  <= i_cfg_data;
                rcfs_pkg::CFG_STEP_PERIOD: r_step_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red       = r_out[0];
    assign o_green     = r_out[1];
    assign o_blue      = r_out[2];
    assign o_last_fill = r_out_last;

    // checks
    `RCFS_ASSERT_IMPL(a_busy_seg_range, r_busy, r_seg < SEG_W'(PALETTE_SIZE),
                      "segment index out of range during a run")
    `RCFS_ASSERT_IMPL(a_acc_bound, 1'b1,
                      (r_acc[0] <= LIM) && (r_acc[1] <= LIM) && (r_acc[2] <= LIM),
                      "accumulator above full scale")
    `RCFS_ASSERT_IMPL(a_run_end_last, $fell(r_busy), r_last,
                      "run ended without a last fill")
    `RCFS_ASSERT_NEXT(a_out_load, (r_state == rcfs_pkg::S_OUT) && out_free,
                      o_valid && (r_state == rcfs_pkg::S_IDLE),
                      "finished fill not moved to the output register")

endmodule
